FILE: hdl/enctach_pkg.sv
// Shared constants and types for the encoder tachometer.
package enctach_pkg;

    localparam int CH_W     = 2;
    localparam int CAP_W    = 16;
    localparam int SCALE_W  = 24;
    localparam int STOP_W   = 5;
    localparam int SPEED_W  = 15;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 15'h7FFF;
    localparam logic [STOP_W-1:0]  IDLE_MAX  = 5'd31;

    localparam logic [SCALE_W-1:0] DEF_SPEED_SCALE = 24'd300000;
    localparam logic [STOP_W-1:0]  DEF_STOP_TICKS  = 5'd20;

    localparam int DEF_AVG_DEPTH    = 10;
    localparam int DEF_NUM_CHANNELS = 4;

    // Register index, taken from paddr bit 2.
    localparam logic REG_SPEED_SCALE = 1'b0;
    localparam logic REG_STOP_TICKS  = 1'b1;

    // Input mode codes.
    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef struct packed {
        logic               start;
        logic [SCALE_W-1:0] num;
        logic [CAP_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SCALE_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: hdl/enctach_if.sv
// Handshake interfaces for the input and result channels.
interface enctach_in_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [enctach_pkg::CH_W-1:0]    channel;
    logic [enctach_pkg::CAP_W-1:0]   capture_value;

    modport source(output valid, mode, channel, capture_value, input ready);
    modport sink(input valid, mode, channel, capture_value, output ready);
endinterface

interface enctach_out_if;
    logic                            valid;
    logic                            ready;
    logic [enctach_pkg::CH_W-1:0]    out_channel;
    logic [enctach_pkg::SPEED_W-1:0] avg_speed;
    logic [enctach_pkg::SPEED_W-1:0] raw_speed;
    logic                            timed_out;
    logic                            last;

    modport source(output valid, out_channel, avg_speed, raw_speed, timed_out, last,
                   input ready);
    modport sink(input valid, out_channel, avg_speed, raw_speed, timed_out, last,
                 output ready);
endinterface

FILE: hdl/enctach_div.sv
// Serial restoring divider, one quotient bit per cycle.
module enctach_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  enctach_pkg::t_div_req i_req,
    output enctach_pkg::t_div_rsp o_rsp
);
    localparam int NW  = enctach_pkg::SCALE_W;
    localparam int DW  = enctach_pkg::CAP_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [NW-1:0]    r_num;

    logic [DW:0]      rem_sh;
    logic             q_bit;
    logic [DW:0]      rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_num[NW-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_num  <= i_req.num;
            end else if (r_busy) begin
                // The dividend shifts out at the top while quotient bits shift in.
                r_rem <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_num <= {r_num[NW-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

FILE: hdl/enctach_ring.sv
// Speed ring memory with per-entry valid bits; unwritten entries read as zero.
module enctach_ring #(
    parameter int ADDR_W = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [ADDR_W-1:0]                 i_waddr,
    input  logic [enctach_pkg::SPEED_W-1:0]   i_wdata,
    input  logic                              i_re,
    input  logic [ADDR_W-1:0]                 i_raddr,
    output logic [enctach_pkg::SPEED_W-1:0]   o_rdata
);
    localparam int DEPTH = 2 ** ADDR_W;

    logic [enctach_pkg::SPEED_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]                r_valid;
    logic [enctach_pkg::SPEED_W-1:0] r_rdata;
    logic                            r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

FILE: hdl/enctach_regs.sv
// APB configuration registers: speed scale and stop tick limit.
module enctach_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [enctach_pkg::PADDR_W-1:0]     paddr,
    input  logic [enctach_pkg::PDATA_W-1:0]     pwdata,
    output logic [enctach_pkg::PDATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [enctach_pkg::SCALE_W-1:0]     o_speed_scale,
    output logic [enctach_pkg::STOP_W-1:0]      o_stop_ticks
);
    logic [enctach_pkg::SCALE_W-1:0] r_speed_scale;
    logic [enctach_pkg::STOP_W-1:0]  r_stop_ticks;
    logic                            wr_en;
    logic                            reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale <= enctach_pkg::DEF_SPEED_SCALE;
            r_stop_ticks  <= enctach_pkg::DEF_STOP_TICKS;
        end else if (wr_en) begin
            case (reg_sel)
                enctach_pkg::REG_SPEED_SCALE:
                    r_speed_scale <= pwdata[enctach_pkg::SCALE_W-1:0];
                enctach_pkg::REG_STOP_TICKS:
                    r_stop_ticks <= pwdata[enctach_pkg::STOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            enctach_pkg::REG_SPEED_SCALE:
                prdata = enctach_pkg::PDATA_W'(r_speed_scale);
            enctach_pkg::REG_STOP_TICKS:
                prdata = enctach_pkg::PDATA_W'(r_stop_ticks);
            default:
                prdata = '0;
        endcase
    end

    assign o_speed_scale = r_speed_scale;
    assign o_stop_ticks  = r_stop_ticks;

endmodule

FILE: hdl/encoder_tachometer_avg.sv
// Encoder tachometer with a per-channel moving-average ring, top level.
// One transaction is handled at a time. A capture transaction waits on a 24-step serial
// divider for the speed (scale / period); around that wait it reads the channel-state
// memory, writes back the ring and the channel state, and reads the ring's first and last
// slots. The average (ring sum / depth) is a reciprocal multiplication and adds no divider
// pass. A result still waiting in the output register delays the final step. A tick
// transaction reports its timed-out channels one by one, and stalls while the result
// port stalls. The ring has per-entry valid bits, so no clearing pass follows reset; a
// capture on a channel at or above NUM_CHANNELS, or a tick with no timeout, produces no
// result.
module encoder_tachometer_avg #(
    parameter int AVG_DEPTH    = enctach_pkg::DEF_AVG_DEPTH,
    parameter int NUM_CHANNELS = enctach_pkg::DEF_NUM_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    enctach_in_if.sink                      i_in,
    enctach_out_if.source                   o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [enctach_pkg::PADDR_W-1:0] paddr,
    input  logic [enctach_pkg::PDATA_W-1:0] pwdata,
    output logic [enctach_pkg::PDATA_W-1:0] prdata,
    output logic                            pready
);
    localparam int CAP_W   = enctach_pkg::CAP_W;
    localparam int SPEED_W = enctach_pkg::SPEED_W;
    localparam int STOP_W  = enctach_pkg::STOP_W;
    localparam int CH_W    = enctach_pkg::CH_W;
    localparam int IW      = $clog2(AVG_DEPTH);
    localparam int CIW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CK_W    = ((CH_W > CIW) ? CH_W : CIW) + 1;
    localparam int SW      = $clog2(AVG_DEPTH * 32767 + 1);
    localparam int CHM_W   = CAP_W + IW + SW;
    localparam int CHM_D   = 2 ** CIW;
    // Reciprocal of the depth, rounded up; exact for every sum below 2**SW.
    localparam int     RK   = SW + $clog2(AVG_DEPTH);
    localparam longint RM   = ((longint'(1) << RK) + longint'(AVG_DEPTH) - 1)
                              / longint'(AVG_DEPTH);
    localparam int     RM_W = $clog2(RM + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CRD, S_DIV1, S_WR, S_RL, S_R0, S_AVG, S_OUT, S_TICK
    } t_state;

    // Configuration.
    logic [enctach_pkg::SCALE_W-1:0] speed_scale;
    logic [STOP_W-1:0]               stop_ticks;

    enctach_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_speed_scale(speed_scale),
        .o_stop_ticks (stop_ticks)
    );

    // Control and working registers.
    t_state                  r_state;
    logic [CIW-1:0]          r_ch;
    logic [CAP_W-1:0]        r_cap;
    logic [IW-1:0]           r_idx;
    logic [SW-1:0]           r_sum;
    logic [SPEED_W-1:0]      r_raw;
    logic [SPEED_W-1:0]      r_avg;
    logic                    r_last_nz;
    logic [STOP_W-1:0]       r_idle [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_mask;

    logic                    r_out_valid;
    logic [CH_W-1:0]         r_out_ch;
    logic [SPEED_W-1:0]      r_out_avg;
    logic [SPEED_W-1:0]      r_out_raw;
    logic                    r_out_to;
    logic                    r_out_last;

    // Channel state memory: previous capture, ring index and ring sum.
    logic [CHM_W-1:0]        r_chm [CHM_D];
    logic [CHM_D-1:0]        r_chm_vld;
    logic [CHM_W-1:0]        r_chm_rdata;
    logic                    r_chm_rvld;
    logic [CHM_W-1:0]        chm_rd;
    logic                    chm_re;
    logic                    chm_we;
    logic [CHM_W-1:0]        chm_wdata;

    // Ring memory access.
    logic                    ring_we;
    logic                    ring_re;
    logic [CIW+IW-1:0]       ring_raddr;
    logic [SPEED_W-1:0]      ring_rdata;

    enctach_pkg::t_div_req   div_req;
    enctach_pkg::t_div_rsp   div_rsp;

    logic                    in_acc;
    logic                    ch_ok;
    logic [CAP_W-1:0]        old_cap;
    logic [IW-1:0]           old_idx;
    logic [SW-1:0]           old_sum;
    logic [CAP_W-1:0]        period;
    logic [SPEED_W-1:0]      quot_sat;
    logic [IW-1:0]           n_idx;
    logic [SW-1:0]           n_sum;
    logic [SW+RM_W-1:0]      avg_prod;
    logic [SPEED_W-1:0]      avg_div;
    logic                    out_free;
    logic                    out_load;
    logic [STOP_W-1:0]       n_idle [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] n_mask;
    logic [CIW-1:0]          tick_ch;
    logic [NUM_CHANNELS-1:0] tick_rest;

    assign in_acc   = i_in.valid && i_in.ready;
    assign ch_ok    = (CK_W'(i_in.channel) < CK_W'(NUM_CHANNELS));
    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ((r_state == S_OUT) || (r_state == S_TICK)) && out_free;
    assign i_in.ready = (r_state == S_IDLE);

    assign chm_rd  = r_chm_rvld ? r_chm_rdata : '0;
    assign old_cap = chm_rd[CHM_W-1 -: CAP_W];
    assign old_idx = chm_rd[SW +: IW];
    assign old_sum = chm_rd[SW-1:0];

    // Wrap rule: a capture that is not greater gives the wrapped difference less one.
    assign period = (r_cap > old_cap) ? (r_cap - old_cap)
                                      : (r_cap + {CAP_W{1'b1}} - old_cap);

    assign quot_sat = (div_rsp.quot > enctach_pkg::SCALE_W'(enctach_pkg::SPEED_MAX))
                    ? enctach_pkg::SPEED_MAX : div_rsp.quot[SPEED_W-1:0];

    assign n_idx = (r_idx == IW'(AVG_DEPTH - 1)) ? '0 : r_idx + 1'b1;
    assign n_sum = r_sum - SW'(ring_rdata) + SW'(r_raw);

    assign avg_prod = (SW+RM_W)'(r_sum) * (SW+RM_W)'(RM);
    assign avg_div  = SPEED_W'(avg_prod >> RK);

    // Tick: every counter advances at once; the timed-out set is then reported in turn.
    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            logic [STOP_W-1:0] inc;
            inc = (r_idle[c] == enctach_pkg::IDLE_MAX) ? r_idle[c] : r_idle[c] + 1'b1;
            n_mask[c] = (inc >= stop_ticks);
            n_idle[c] = n_mask[c] ? '0 : inc;
        end
    end

    always_comb begin
        tick_ch = '0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                tick_ch = CIW'(c);
            end
        end
        tick_rest = r_mask & ~(NUM_CHANNELS'(1) << tick_ch);
    end

    // Memory control.
    always_comb begin
        chm_re     = in_acc && (i_in.mode == enctach_pkg::MODE_CAPTURE) && ch_ok;
        chm_we     = (r_state == S_WR);
        chm_wdata  = {r_cap, n_idx, n_sum};
        ring_we    = (r_state == S_WR);
        ring_re    = 1'b0;
        ring_raddr = {r_ch, old_idx};
        case (r_state)
            S_CRD: begin
                ring_re    = 1'b1;
                ring_raddr = {r_ch, old_idx};
            end
            S_RL: begin
                ring_re    = 1'b1;
                ring_raddr = {r_ch, IW'(AVG_DEPTH - 1)};
            end
            S_R0: begin
                ring_re    = 1'b1;
                ring_raddr = {r_ch, {IW{1'b0}}};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (chm_we) begin
            r_chm[r_ch] <= chm_wdata;
        end
        if (chm_re) begin
            r_chm_rdata <= r_chm[CIW'(i_in.channel)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chm_vld  <= '0;
            r_chm_rvld <= 1'b0;
        end else begin
            if (chm_we) begin
                r_chm_vld[r_ch] <= 1'b1;
            end
            if (chm_re) begin
                r_chm_rvld <= r_chm_vld[CIW'(i_in.channel)];
            end
        end
    end

    enctach_ring #(
        .ADDR_W(CIW + IW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (ring_we),
        .i_waddr({r_ch, r_idx}),
        .i_wdata(r_raw),
        .i_re   (ring_re),
        .i_raddr(ring_raddr),
        .o_rdata(ring_rdata)
    );

    always_comb begin
        div_req.start = (r_state == S_CRD);
        div_req.num   = speed_scale;
        div_req.den   = period;
    end

    enctach_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Sequencer, idle counters and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_idle[c] <= '0;
            end
        end else begin
            r_out_valid <= out_load || (r_out_valid && !o_out.ready);
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.mode == enctach_pkg::MODE_CAPTURE) begin
                            if (ch_ok) begin
                                r_ch    <= CIW'(i_in.channel);
                                r_cap   <= i_in.capture_value;
                                r_idle[CIW'(i_in.channel)] <= '0;
                                r_state <= S_CRD;
                            end
                        end else begin
                            for (int c = 0; c < NUM_CHANNELS; c++) begin
                                r_idle[c] <= n_idle[c];
                            end
                            r_mask <= n_mask;
                            if (n_mask != '0) begin
                                r_state <= S_TICK;
                            end
                        end
                    end
                end
                S_CRD: begin
                    r_idx   <= old_idx;
                    r_sum   <= old_sum;
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        r_raw   <= quot_sat;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    // The ring still shows the overwritten entry here.
                    r_sum   <= n_sum;
                    r_state <= S_RL;
                end
                S_RL: begin
                    r_state <= S_R0;
                end
                S_R0: begin
                    r_last_nz <= (ring_rdata != '0);
                    r_state   <= S_AVG;
                end
                S_AVG: begin
                    r_avg   <= r_last_nz ? avg_div : ring_rdata;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_ch    <= CH_W'(r_ch);
                        r_out_avg   <= r_avg;
                        r_out_raw   <= r_raw;
                        r_out_to    <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_TICK: begin
                    if (out_free) begin
                        r_out_ch    <= CH_W'(tick_ch);
                        r_out_avg   <= '0;
                        r_out_raw   <= '0;
                        r_out_to    <= 1'b1;
                        r_out_last  <= (tick_rest == '0);
                        r_mask      <= tick_rest;
                        if (tick_rest == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_ch;
    assign o_out.avg_speed   = r_out_avg;
    assign o_out.raw_speed   = r_out_raw;
    assign o_out.timed_out   = r_out_to;
    assign o_out.last        = r_out_last;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_tick_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (r_mask != '0))
        else $error("tick reporting with no timed-out channel left");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.timed_out) |-> (o_out.avg_speed == '0 && o_out.raw_speed == '0))
        else $error("timeout result with nonzero speed");

    a_capture_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_out.valid && o_out.last && !o_out.timed_out))
        else $error("capture result not presented as a single final result");

endmodule
